FILE: sv/glc_pkg.sv
// ----------------------------------------------------------------------------
// glc_pkg: shared types and codes of the guest lifecycle controller
// Command, status, phase and hook codes, plus the structs that carry one
// command, the configuration, the lifecycle state and one result.
// ----------------------------------------------------------------------------
package glc_pkg;

  localparam int unsigned FuncW   = 3;
  localparam int unsigned StatusW = 3;
  localparam int unsigned PhaseW  = 2;
  localparam int unsigned HookW   = 6;
  localparam int unsigned WordW   = 32;
  localparam int unsigned CfgIdxW = 2;

  // Command codes.
  localparam logic [FuncW-1:0] FUNC_CREATE  = 3'd0;
  localparam logic [FuncW-1:0] FUNC_BOOT    = 3'd1;
  localparam logic [FuncW-1:0] FUNC_SUSPEND = 3'd2;
  localparam logic [FuncW-1:0] FUNC_RESUME  = 3'd3;
  localparam logic [FuncW-1:0] FUNC_DESTROY = 3'd4;

  // Status codes.
  localparam logic [StatusW-1:0] ST_OK        = 3'd0;
  localparam logic [StatusW-1:0] ST_BAD_OS    = 3'd1;
  localparam logic [StatusW-1:0] ST_DEAD      = 3'd2;
  localparam logic [StatusW-1:0] ST_NOT_READY = 3'd3;
  localparam logic [StatusW-1:0] ST_BAD_ID    = 3'd4;
  localparam logic [StatusW-1:0] ST_BAD_STATE = 3'd5;

  // Lifecycle phases.
  localparam logic [PhaseW-1:0] PH_READY     = 2'd0;
  localparam logic [PhaseW-1:0] PH_RUNNING   = 2'd1;
  localparam logic [PhaseW-1:0] PH_SUSPENDED = 2'd2;
  localparam logic [PhaseW-1:0] PH_DEAD      = 2'd3;

  // Bit positions in the hook masks.
  localparam int unsigned HK_RESET    = 0;
  localparam int unsigned HK_START    = 1;
  localparam int unsigned HK_SUSPEND  = 2;
  localparam int unsigned HK_RESUME   = 3;
  localparam int unsigned HK_TEARDOWN = 4;
  localparam int unsigned HK_QUIESCE  = 5;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_GUEST_IDENT   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_OS_KIND       = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_HOOKS_PRESENT = 2'd2;

  localparam logic [WordW-1:0] OS_KIND_RESET = 32'd1;

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic             word_present;
    logic [WordW-1:0] word_value;
    logic             reset_ok;
    logic             start_ok;
    logic             suspend_ok;
    logic             resume_ok;
    logic             teardown_ok;
  } cmd_t;

  typedef struct packed {
    logic [WordW-1:0] guest_ident;
    logic [WordW-1:0] os_kind;
    logic [HookW-1:0] hooks_present;
  } cfg_t;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic              has_started;
  } life_t;

  typedef struct packed {
    logic               handled;
    logic [StatusW-1:0] status;
    logic [WordW-1:0]   reply_ident;
    logic [HookW-1:0]   hooks_fired;
    logic [PhaseW-1:0]  life_state;
  } result_t;

endpackage

FILE: sv/guest_lifecycle_controller_top.sv
// ----------------------------------------------------------------------------
// guest_lifecycle_controller_top: lifecycle controller for one guest
// Takes create, boot, suspend, resume and destroy requests, applies the
// lifecycle rules and reports status, fired hooks and the resulting phase.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                  Payload
// -------   ---------  -------------------------  ---------------------------
// in        input      in_valid_i / in_ready_o    func_i, word_*, *_ok_i
// out       output     out_valid_o / out_ready_i  handled_o, status_o, ...
// cfg       input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// Each request waits in the input register and is decided as it moves to
// the result register; one request is taken every cycle while the output
// is drained. The lifecycle state is updated on that same edge, so
// back-to-back requests see the state left by their predecessor.
// A stalled output holds its result; the input register still takes one more
// request behind it. Reset puts the guest in the ready phase, not started.
// Configuration writes are always accepted; an index past the last register
// is ignored.

module guest_lifecycle_controller_top
  import glc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,

  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [FuncW-1:0]   func_i,
  input  logic               word_present_i,
  input  logic [WordW-1:0]   word_value_i,
  input  logic               reset_ok_i,
  input  logic               start_ok_i,
  input  logic               suspend_ok_i,
  input  logic               resume_ok_i,
  input  logic               teardown_ok_i,

  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               handled_o,
  output logic [StatusW-1:0] status_o,
  output logic [WordW-1:0]   reply_ident_o,
  output logic [HookW-1:0]   hooks_fired_o,
  output logic [PhaseW-1:0]  life_state_o,

  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [WordW-1:0]   cfg_data_i
);

  // Configuration registers.
  cfg_t    cfg_q;

  // Input stage, lifecycle state and result stage.
  logic    in_valid_q;
  cmd_t    cmd_q;
  life_t   life_q, life_d;
  logic    out_valid_q;
  result_t res_q, res_d;

  logic    advance;
  logic    in_accept;

  // The staged request moves forward whenever the result register is free
  // or is being emptied in this cycle.
  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign in_accept   = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.guest_ident   <= '0;
      cfg_q.os_kind       <= OS_KIND_RESET;
      cfg_q.hooks_present <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_GUEST_IDENT:   cfg_q.guest_ident   <= cfg_data_i;
        CFG_OS_KIND:       cfg_q.os_kind       <= cfg_data_i;
        CFG_HOOKS_PRESENT: cfg_q.hooks_present <= cfg_data_i[HookW-1:0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q.func         <= func_i;
      cmd_q.word_present <= word_present_i;
      cmd_q.word_value   <= word_value_i;
      cmd_q.reset_ok     <= reset_ok_i;
      cmd_q.start_ok     <= start_ok_i;
      cmd_q.suspend_ok   <= suspend_ok_i;
      cmd_q.resume_ok    <= resume_ok_i;
      cmd_q.teardown_ok  <= teardown_ok_i;
    end
  end

  glc_step u_step (
    .cmd_i  (cmd_q),
    .cfg_i  (cfg_q),
    .life_i (life_q),
    .res_o  (res_d),
    .life_o (life_d)
  );

  // Lifecycle state and result register move together.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      life_q.phase       <= PH_READY;
      life_q.has_started <= 1'b0;
      out_valid_q        <= 1'b0;
    end else begin
      if (advance) begin
        life_q      <= life_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign handled_o     = res_q.handled;
  assign status_o      = res_q.status;
  assign reply_ident_o = res_q.reply_ident;
  assign hooks_fired_o = res_q.hooks_fired;
  assign life_state_o  = res_q.life_state;

  // The lifecycle state only moves when a request is decided.
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(life_q))
    else $error("lifecycle state changed without a decided request");

  // The reported phase is the state left behind by that request.
  a_phase_reported: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (out_valid_q && (res_q.life_state == life_q.phase)))
    else $error("reported phase differs from the stored phase");

  // Unknown commands fire nothing and leave the state alone.
  a_unknown_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (cmd_q.func != FUNC_CREATE) && (cmd_q.func != FUNC_BOOT) &&
     (cmd_q.func != FUNC_SUSPEND) && (cmd_q.func != FUNC_RESUME) &&
     (cmd_q.func != FUNC_DESTROY))
    |=> (!res_q.handled && (res_q.hooks_fired == '0) && $stable(life_q)))
    else $error("unknown command had an effect");

  // Leaving the dead phase always goes through a fired reset hook.
  a_revive_by_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (life_q.phase == PH_DEAD) && (life_d.phase != PH_DEAD))
    |-> res_d.hooks_fired[HK_RESET])
    else $error("dead guest revived without the reset hook");

endmodule

FILE: sv/glc_step.sv
// ----------------------------------------------------------------------------
// glc_step: decision logic for one lifecycle command
// Checks identity, os type and phase rules, picks the hooks to fire and
// forms the result and the next lifecycle state.
// ----------------------------------------------------------------------------
module glc_step
  import glc_pkg::*;
(
  input  cmd_t    cmd_i,
  input  cfg_t    cfg_i,
  input  life_t   life_i,
  output result_t res_o,
  output life_t   life_o
);

  logic              id_ok;
  logic [WordW-1:0]  want_os;
  logic              suspended_ok;
  logic [HookW-1:0]  hp;
  life_t             nxt;

  assign hp      = cfg_i.hooks_present;
  assign id_ok   = cmd_i.word_present && (cmd_i.word_value == cfg_i.guest_ident);
  assign want_os = cmd_i.word_present ? cmd_i.word_value : '0;

  always_comb begin
    nxt               = life_i;
    suspended_ok      = 1'b1;
    res_o.handled     = 1'b1;
    res_o.status      = ST_OK;
    res_o.reply_ident = '0;
    res_o.hooks_fired = '0;

    unique case (cmd_i.func) inside
      FUNC_CREATE: begin
        if ((want_os != '0) && (want_os != cfg_i.os_kind)) begin
          res_o.status = ST_BAD_OS;
        end else if (life_i.phase == PH_DEAD) begin
          if (!hp[HK_RESET]) begin
            res_o.status = ST_DEAD;
          end else begin
            res_o.hooks_fired[HK_RESET] = 1'b1;
            if (!cmd_i.reset_ok) begin
              res_o.status = ST_NOT_READY;
            end else begin
              nxt.has_started   = 1'b0;
              nxt.phase         = PH_READY;
              res_o.reply_ident = cfg_i.guest_ident;
            end
          end
        end else begin
          res_o.reply_ident = cfg_i.guest_ident;
        end
      end
      FUNC_BOOT: begin
        if (!id_ok) begin
          res_o.status = ST_BAD_ID;
        end else if (life_i.phase == PH_DEAD) begin
          res_o.status = ST_DEAD;
        end else if (life_i.phase == PH_SUSPENDED) begin
          res_o.status = ST_BAD_STATE;
        end else if (life_i.has_started) begin
          nxt.phase = PH_RUNNING;
        end else if (!hp[HK_START]) begin
          res_o.status = ST_NOT_READY;
        end else begin
          res_o.hooks_fired[HK_START] = 1'b1;
          if (!cmd_i.start_ok) begin
            res_o.status = ST_NOT_READY;
          end else begin
            nxt.has_started = 1'b1;
            nxt.phase       = PH_RUNNING;
          end
        end
      end
      FUNC_SUSPEND, FUNC_RESUME: begin
        if (!id_ok) begin
          res_o.status = ST_BAD_ID;
        end else if (life_i.phase == PH_DEAD) begin
          res_o.status = ST_DEAD;
        end else if (!life_i.has_started || (life_i.phase == PH_READY)) begin
          res_o.status = ST_BAD_STATE;
        end else if (cmd_i.func == FUNC_SUSPEND) begin
          // Suspending an already suspended guest is a quiet success.
          if (life_i.phase != PH_SUSPENDED) begin
            if (!hp[HK_SUSPEND]) begin
              res_o.status = ST_NOT_READY;
            end else begin
              res_o.hooks_fired[HK_SUSPEND] = 1'b1;
              if (!cmd_i.suspend_ok) begin
                res_o.status = ST_NOT_READY;
              end else begin
                res_o.hooks_fired[HK_QUIESCE] = hp[HK_QUIESCE];
                nxt.phase = PH_SUSPENDED;
              end
            end
          end
        end else if (life_i.phase != PH_SUSPENDED) begin
          nxt.phase = PH_RUNNING;
        end else if (!hp[HK_RESUME]) begin
          res_o.status = ST_NOT_READY;
        end else begin
          res_o.hooks_fired[HK_RESUME] = 1'b1;
          if (!cmd_i.resume_ok) begin
            res_o.status = ST_NOT_READY;
          end else begin
            nxt.phase = PH_RUNNING;
          end
        end
      end
      FUNC_DESTROY: begin
        if (!id_ok) begin
          res_o.status = ST_BAD_ID;
        end else if (life_i.phase != PH_DEAD) begin
          // A live guest is suspended first, then torn down.
          if (life_i.phase != PH_SUSPENDED) begin
            if (!hp[HK_SUSPEND]) begin
              res_o.status = ST_NOT_READY;
              suspended_ok = 1'b0;
            end else begin
              res_o.hooks_fired[HK_SUSPEND] = 1'b1;
              if (!cmd_i.suspend_ok) begin
                res_o.status = ST_NOT_READY;
                suspended_ok = 1'b0;
              end else begin
                res_o.hooks_fired[HK_QUIESCE] = hp[HK_QUIESCE];
                nxt.phase = PH_SUSPENDED;
              end
            end
          end
          if (suspended_ok) begin
            res_o.hooks_fired[HK_TEARDOWN] = hp[HK_TEARDOWN];
            if (hp[HK_TEARDOWN] && !cmd_i.teardown_ok) begin
              res_o.status = ST_NOT_READY;
            end else begin
              nxt.has_started = 1'b0;
              nxt.phase       = PH_DEAD;
            end
          end
        end
      end
      default: begin
        res_o.handled = 1'b0;
      end
    endcase

    res_o.life_state = nxt.phase;
  end

  assign life_o = nxt;

endmodule

FILE: tb/glc_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// glc_result_checker: lifecycle predictor and result comparison
// Tracks configuration writes and accepted requests, predicts the result of
// each request from its own copy of the lifecycle state, and compares every
// accepted result with the oldest prediction.
// ----------------------------------------------------------------------------

module glc_result_checker
  import glc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,

  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [FuncW-1:0]   func_i,
  input  logic               word_present_i,
  input  logic [WordW-1:0]   word_value_i,
  input  logic               reset_ok_i,
  input  logic               start_ok_i,
  input  logic               suspend_ok_i,
  input  logic               resume_ok_i,
  input  logic               teardown_ok_i,

  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic               handled_i,
  input  logic [StatusW-1:0] status_i,
  input  logic [WordW-1:0]   reply_ident_i,
  input  logic [HookW-1:0]   hooks_fired_i,
  input  logic [PhaseW-1:0]  life_state_i,

  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [WordW-1:0]   cfg_data_i,

  output int unsigned        mismatch_count_o,
  output int unsigned        pending_o
);

  cfg_t        guest_cfg;
  life_t       life;
  result_t     predicted_replies[$];
  int unsigned mismatches;

  // Applies one request to the lifecycle copy and returns the reply it earns.
  function automatic result_t lifecycle_step(input cmd_t c);
    result_t          r;
    logic             id_match;
    logic             go_on;
    logic [WordW-1:0] os_req;
    r         = '0;
    r.handled = 1'b1;
    r.status  = ST_OK;
    id_match  = c.word_present && (c.word_value == guest_cfg.guest_ident);
    case (c.func)
      FUNC_CREATE: begin
        os_req = c.word_present ? c.word_value : '0;
        if (os_req != '0 && os_req != guest_cfg.os_kind) begin
          r.status = ST_BAD_OS;
        end else if (life.phase == PH_DEAD && !guest_cfg.hooks_present[HK_RESET]) begin
          r.status = ST_DEAD;
        end else if (life.phase == PH_DEAD && !c.reset_ok) begin
          r.hooks_fired[HK_RESET] = 1'b1;
          r.status = ST_NOT_READY;
        end else begin
          if (life.phase == PH_DEAD) begin
            r.hooks_fired[HK_RESET] = 1'b1;
            life.has_started = 1'b0;
            life.phase = PH_READY;
          end
          r.reply_ident = guest_cfg.guest_ident;
        end
      end
      FUNC_BOOT: begin
        if (!id_match) begin
          r.status = ST_BAD_ID;
        end else if (life.phase == PH_DEAD) begin
          r.status = ST_DEAD;
        end else if (life.phase != PH_READY && life.phase != PH_RUNNING) begin
          r.status = ST_BAD_STATE;
        end else if (!life.has_started && !guest_cfg.hooks_present[HK_START]) begin
          r.status = ST_NOT_READY;
        end else if (!life.has_started && !c.start_ok) begin
          r.hooks_fired[HK_START] = 1'b1;
          r.status = ST_NOT_READY;
        end else begin
          if (!life.has_started) begin
            r.hooks_fired[HK_START] = 1'b1;
            life.has_started = 1'b1;
          end
          life.phase = PH_RUNNING;
        end
      end
      FUNC_SUSPEND: begin
        if (!id_match) begin
          r.status = ST_BAD_ID;
        end else if (life.phase == PH_DEAD) begin
          r.status = ST_DEAD;
        end else if (!life.has_started ||
                     (life.phase != PH_RUNNING && life.phase != PH_SUSPENDED)) begin
          r.status = ST_BAD_STATE;
        end else if (life.phase == PH_RUNNING) begin
          if (!guest_cfg.hooks_present[HK_SUSPEND]) begin
            r.status = ST_NOT_READY;
          end else begin
            r.hooks_fired[HK_SUSPEND] = 1'b1;
            if (!c.suspend_ok) begin
              r.status = ST_NOT_READY;
            end else begin
              r.hooks_fired[HK_QUIESCE] = guest_cfg.hooks_present[HK_QUIESCE];
              life.phase = PH_SUSPENDED;
            end
          end
        end
      end
      FUNC_RESUME: begin
        if (!id_match) begin
          r.status = ST_BAD_ID;
        end else if (life.phase == PH_DEAD) begin
          r.status = ST_DEAD;
        end else if (!life.has_started ||
                     (life.phase != PH_RUNNING && life.phase != PH_SUSPENDED)) begin
          r.status = ST_BAD_STATE;
        end else if (life.phase == PH_SUSPENDED) begin
          if (!guest_cfg.hooks_present[HK_RESUME]) begin
            r.status = ST_NOT_READY;
          end else begin
            r.hooks_fired[HK_RESUME] = 1'b1;
            if (!c.resume_ok) r.status = ST_NOT_READY;
            else life.phase = PH_RUNNING;
          end
        end else begin
          life.phase = PH_RUNNING;
        end
      end
      FUNC_DESTROY: begin
        if (!id_match) begin
          r.status = ST_BAD_ID;
        end else if (life.phase != PH_DEAD) begin
          go_on = 1'b1;
          // A guest that is not yet suspended gets suspended on the way down.
          if (life.phase != PH_SUSPENDED) begin
            if (!guest_cfg.hooks_present[HK_SUSPEND]) begin
              r.status = ST_NOT_READY;
              go_on = 1'b0;
            end else begin
              r.hooks_fired[HK_SUSPEND] = 1'b1;
              if (!c.suspend_ok) begin
                r.status = ST_NOT_READY;
                go_on = 1'b0;
              end else begin
                r.hooks_fired[HK_QUIESCE] = guest_cfg.hooks_present[HK_QUIESCE];
                life.phase = PH_SUSPENDED;
              end
            end
          end
          if (go_on && guest_cfg.hooks_present[HK_TEARDOWN]) begin
            r.hooks_fired[HK_TEARDOWN] = 1'b1;
            if (!c.teardown_ok) begin
              r.status = ST_NOT_READY;
              go_on = 1'b0;
            end
          end
          if (go_on) begin
            life.has_started = 1'b0;
            life.phase = PH_DEAD;
          end
        end
      end
      default: begin
        r.handled = 1'b0;
      end
    endcase
    r.life_state = life.phase;
    return r;
  endfunction

  task automatic compare_field(input string label, input logic [WordW-1:0] want,
                               input logic [WordW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, label, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    result_t seen;
    result_t want;
    if (!rst_ni) begin
      guest_cfg.guest_ident   = '0;
      guest_cfg.os_kind       = OS_KIND_RESET;
      guest_cfg.hooks_present = '0;
      life.phase              = PH_READY;
      life.has_started        = 1'b0;
      predicted_replies.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_GUEST_IDENT:   guest_cfg.guest_ident = cfg_data_i;
          CFG_OS_KIND:       guest_cfg.os_kind = cfg_data_i;
          CFG_HOOKS_PRESENT: guest_cfg.hooks_present = cfg_data_i[HookW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        predicted_replies.push_back(lifecycle_step({func_i, word_present_i, word_value_i,
                                                    reset_ok_i, start_ok_i, suspend_ok_i,
                                                    resume_ok_i, teardown_ok_i}));
      end
      if (out_valid_i && out_ready_i) begin
        seen = {handled_i, status_i, reply_ident_i, hooks_fired_i, life_state_i};
        if (predicted_replies.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual 0x%0h", $time, seen);
          mismatches++;
        end else begin
          want = predicted_replies.pop_front();
          compare_field("handled", WordW'(want.handled), WordW'(seen.handled));
          compare_field("status", WordW'(want.status), WordW'(seen.status));
          compare_field("reply_ident", want.reply_ident, seen.reply_ident);
          compare_field("hooks_fired", WordW'(want.hooks_fired), WordW'(seen.hooks_fired));
          compare_field("life_state", WordW'(want.life_state), WordW'(seen.life_state));
        end
      end
    end
    mismatch_count_o <= mismatches;
    pending_o        <= predicted_replies.size();
  end

endmodule

FILE: tb/tb_guest_lifecycle_controller_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_guest_lifecycle_controller_top: testbench of the guest lifecycle block
// Drives directed and random lifecycle requests and configuration settings
// into the block, throttles both channels at random, and reports the verdict
// from the mismatch count that the result checker collects.
// ----------------------------------------------------------------------------

module tb_guest_lifecycle_controller_top;
  import glc_pkg::*;

  // Index past the last register; the block must ignore writes to it.
  localparam logic [CfgIdxW-1:0] CFG_SPARE = CFG_HOOKS_PRESENT + CfgIdxW'(1);

  // Lowest command code that the block does not know.
  localparam logic [FuncW-1:0] FUNC_UNKNOWN_LO = FUNC_DESTROY + FuncW'(1);

  // Hook outcome bits of a request, ordered as in make_request.
  localparam logic [4:0] OK_RESET    = 5'b10000;
  localparam logic [4:0] OK_START    = 5'b01000;
  localparam logic [4:0] OK_SUSPEND  = 5'b00100;
  localparam logic [4:0] OK_RESUME   = 5'b00010;
  localparam logic [4:0] OK_TEARDOWN = 5'b00001;
  localparam logic [4:0] ALL_OK      = 5'b11111;
  localparam logic [4:0] NONE_OK     = 5'b00000;

  localparam int RANDOM_PHASES   = 8;
  localparam int PHASE_REQUESTS  = 210;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 4;
  localparam int WATCHDOG_LIMIT  = 2000;

  logic clk = 1'b0;
  logic rst_n;

  // Request channel. The whole payload sits in one struct register so that
  // it changes in a single step together with the valid.
  logic               in_valid;
  logic               in_ready;
  cmd_t               in_cmd;

  logic               out_valid;
  logic               out_ready;
  logic               handled;
  logic [StatusW-1:0] status;
  logic [WordW-1:0]   reply_ident;
  logic [HookW-1:0]   hooks_fired;
  logic [PhaseW-1:0]  life_state;

  logic               cfg_valid;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [WordW-1:0]   cfg_data;

  int unsigned mismatch_count;
  int unsigned pending_count;
  int unsigned stuck_cycles = 0;

  // Settings currently held by the block; random requests aim at them.
  cfg_t settings;

  // When set, neither side idles. hold_req asks the result side for one long
  // hold-off; the result side sets hold_done once it has served it.
  bit steady;
  bit hold_req;
  bit hold_done;

  always #5 clk = ~clk;

  guest_lifecycle_controller_top i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .func_i         (in_cmd.func),
    .word_present_i (in_cmd.word_present),
    .word_value_i   (in_cmd.word_value),
    .reset_ok_i     (in_cmd.reset_ok),
    .start_ok_i     (in_cmd.start_ok),
    .suspend_ok_i   (in_cmd.suspend_ok),
    .resume_ok_i    (in_cmd.resume_ok),
    .teardown_ok_i  (in_cmd.teardown_ok),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .handled_o      (handled),
    .status_o       (status),
    .reply_ident_o  (reply_ident),
    .hooks_fired_o  (hooks_fired),
    .life_state_o   (life_state),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  glc_result_checker i_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .func_i           (in_cmd.func),
    .word_present_i   (in_cmd.word_present),
    .word_value_i     (in_cmd.word_value),
    .reset_ok_i       (in_cmd.reset_ok),
    .start_ok_i       (in_cmd.start_ok),
    .suspend_ok_i     (in_cmd.suspend_ok),
    .resume_ok_i      (in_cmd.resume_ok),
    .teardown_ok_i    (in_cmd.teardown_ok),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .handled_i        (handled),
    .status_i         (status),
    .reply_ident_i    (reply_ident),
    .hooks_fired_i    (hooks_fired),
    .life_state_i     (life_state),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_count)
  );

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int pick_gap(input bit no_idle);
    int roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 50) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Hook outcomes are given as {reset, start, suspend, resume, teardown}.
  function automatic cmd_t make_request(input logic [FuncW-1:0] f, input logic present,
                                        input logic [WordW-1:0] w, input logic [4:0] oks);
    return {f, present, w, oks};
  endfunction

  // Mostly well-formed requests: the right guest id, an acceptable os type
  // and hooks that succeed, so that the guest travels through all phases.
  // The rest carries wrong ids, wrong os types, missing words and failures.
  function automatic cmd_t random_request();
    cmd_t c;
    int   roll;
    roll = $urandom_range(0, 99);
    if (roll < 15)      c.func = FUNC_CREATE;
    else if (roll < 40) c.func = FUNC_BOOT;
    else if (roll < 60) c.func = FUNC_SUSPEND;
    else if (roll < 78) c.func = FUNC_RESUME;
    else if (roll < 94) c.func = FUNC_DESTROY;
    else c.func = FuncW'($urandom_range(int'(FUNC_UNKNOWN_LO), (1 << FuncW) - 1));
    c.word_present = ($urandom_range(0, 99) < 95);
    roll = $urandom_range(0, 99);
    if (c.func == FUNC_CREATE) begin
      if (roll < 35)      c.word_value = '0;
      else if (roll < 75) c.word_value = settings.os_kind;
      else                c.word_value = $urandom();
    end else begin
      if (roll < 85)      c.word_value = settings.guest_ident;
      else if (roll < 92) c.word_value = settings.guest_ident ^ (32'd1 << $urandom_range(0, 31));
      else                c.word_value = $urandom();
    end
    c.reset_ok    = ($urandom_range(0, 99) < 80);
    c.start_ok    = ($urandom_range(0, 99) < 80);
    c.suspend_ok  = ($urandom_range(0, 99) < 80);
    c.resume_ok   = ($urandom_range(0, 99) < 80);
    c.teardown_ok = ($urandom_range(0, 99) < 80);
    return c;
  endfunction

  // Offers one request and returns at the edge that accepts it. A request
  // that follows without a gap keeps valid high and only swaps the payload.
  task automatic send_request(input cmd_t c);
    int gap;
    gap = pick_gap(steady);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd   <= c;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stops offering and waits until every predicted result has come back.
  // The checker's count is registered, so the loop waits for an edge before it reads it.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  // Writes all registers back to back, plus the unused index when asked.
  // Only called while the block holds no request.
  task automatic write_settings(input cfg_t s, input bit spare);
    logic [WordW-1:0]   vals [4];
    logic [CfgIdxW-1:0] idxs [4];
    vals = '{s.guest_ident, s.os_kind, {{(WordW-HookW){1'b0}}, s.hooks_present}, $urandom()};
    idxs = '{CFG_GUEST_IDENT, CFG_OS_KIND, CFG_HOOKS_PRESENT, CFG_SPARE};
    cfg_valid <= 1'b1;
    for (int k = 0; k < (spare ? 4 : 3); k++) begin
      cfg_index <= idxs[k];
      cfg_data  <= vals[k];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    settings = s;
  endtask

  // Result side: ready in random bursts with random gaps between them, and
  // one long hold-off on request while the request side keeps offering, so
  // that the block fills up and has to stall its input.
  initial begin : result_sink
    int burst;
    int gap;
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      burst = $urandom_range(1, 12);
      out_ready <= 1'b1;
      repeat (burst) @(posedge clk);
      gap = pick_gap(steady);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // Watchdog: any accepted request, taken result or register write counts as progress.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    cfg_t next_cfg;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_cmd       <= '0;
    cfg_valid    <= 1'b0;
    cfg_index    <= CFG_GUEST_IDENT;
    cfg_data     <= '0;
    steady    = 1'b0;
    hold_req  = 1'b0;
    hold_done = 1'b0;
    settings.guest_ident   = '0;
    settings.os_kind       = OS_KIND_RESET;
    settings.hooks_present = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, first on the reset settings: no hooks, guest id zero,
    // os type one. Unknown commands, a missing word on a guest command and
    // on create, a wrong os type, and missing start and suspend hooks.
    send_request(make_request(FUNC_UNKNOWN_LO, 1'b1, '1, ALL_OK));
    send_request(make_request('1, 1'b0, '0, NONE_OK));
    send_request(make_request(FUNC_BOOT, 1'b0, '0, ALL_OK));
    send_request(make_request(FUNC_BOOT, 1'b1, '0, ALL_OK));
    send_request(make_request(FUNC_SUSPEND, 1'b1, '0, ALL_OK));
    send_request(make_request(FUNC_CREATE, 1'b0, '1, NONE_OK));
    send_request(make_request(FUNC_CREATE, 1'b1, 32'd2, ALL_OK));
    send_request(make_request(FUNC_DESTROY, 1'b1, '0, ALL_OK));
    drain_results();

    // All hooks present and all-ones id and os type: walk the guest through
    // every phase, with each hook failing once on the way.
    next_cfg.guest_ident   = '1;
    next_cfg.os_kind       = '1;
    next_cfg.hooks_present = '1;
    write_settings(next_cfg, 1'b1);
    send_request(make_request(FUNC_CREATE, 1'b1, '1, ALL_OK));
    send_request(make_request(FUNC_BOOT, 1'b1, '1, ALL_OK & ~OK_START));
    send_request(make_request(FUNC_BOOT, 1'b1, '1, ALL_OK));
    send_request(make_request(FUNC_BOOT, 1'b1, '1, NONE_OK));
    send_request(make_request(FUNC_RESUME, 1'b1, '1, NONE_OK));
    send_request(make_request(FUNC_SUSPEND, 1'b1, '1, ALL_OK & ~OK_SUSPEND));
    send_request(make_request(FUNC_SUSPEND, 1'b1, '1, ALL_OK));
    send_request(make_request(FUNC_RESUME, 1'b1, '1, ALL_OK & ~OK_RESUME));
    send_request(make_request(FUNC_BOOT, 1'b1, '1, ALL_OK));
    // Teardown fails on a suspended guest, then succeeds.
    send_request(make_request(FUNC_DESTROY, 1'b1, '1, ALL_OK & ~OK_TEARDOWN));
    send_request(make_request(FUNC_DESTROY, 1'b1, '1, ALL_OK));
    send_request(make_request(FUNC_BOOT, 1'b1, '1, ALL_OK));
    send_request(make_request(FUNC_DESTROY, 1'b1, '1, NONE_OK));
    send_request(make_request(FUNC_CREATE, 1'b1, '0, ALL_OK & ~OK_RESET));
    send_request(make_request(FUNC_CREATE, 1'b1, '1, ALL_OK));
    drain_results();

    // Only the suspend hook and an os type of zero: destroy succeeds without
    // a teardown hook, and create on the dead guest then has no reset hook.
    next_cfg.guest_ident   = '0;
    next_cfg.os_kind       = '0;
    next_cfg.hooks_present = '0;
    next_cfg.hooks_present[HK_SUSPEND] = 1'b1;
    write_settings(next_cfg, 1'b0);
    send_request(make_request(FUNC_DESTROY, 1'b1, '0, ALL_OK));
    send_request(make_request(FUNC_CREATE, 1'b1, '0, ALL_OK));
    send_request(make_request(FUNC_CREATE, 1'b1, 32'd5, ALL_OK));
    drain_results();

    // Random part. Each phase runs on its own settings: extreme ids and os
    // types in some, all hooks in half of them, none or a random subset in others.
    // Phase three holds off the result side for a long stretch while
    // requests keep coming without gaps; phase five runs without any idling.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p % 4 == 0)      next_cfg.guest_ident = '0;
      else if (p % 4 == 1) next_cfg.guest_ident = '1;
      else                 next_cfg.guest_ident = $urandom();
      if (p == 2)          next_cfg.os_kind = '0;
      else if (p == 5)     next_cfg.os_kind = '1;
      else if (p == 1)     next_cfg.os_kind = OS_KIND_RESET;
      else                 next_cfg.os_kind = $urandom();
      if (p == 6)                      next_cfg.hooks_present = '0;
      else if (p == 1 || p == 4 || p == 7) next_cfg.hooks_present = HookW'($urandom_range(0, 63));
      else                             next_cfg.hooks_present = '1;
      write_settings(next_cfg, p == 4);
      steady = (p == 3 || p == 5);
      if (p == 3) hold_req = 1'b1;
      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        send_request(random_request());
      end
      drain_results();
    end

    // Everything has come back; give the block a few more cycles so that
    // a stray extra result would still be caught.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
